/* src/pga_pkg.sv */
// shared types, codes and defaults for the partition gap allocator
package pga_pkg;

  localparam int NUM_SLOTS_DEF = 4;

  // command opcodes
  typedef enum logic [1:0] {
    OP_CREATE = 2'd0,
    OP_DELETE = 2'd1,
    OP_RESIZE = 2'd2,
    OP_NOP    = 2'd3
  } op_t;

  // fit policies
  typedef enum logic [1:0] {
    FIT_FIRST = 2'd0,
    FIT_BEST  = 2'd1,
    FIT_WORST = 2'd2,
    FIT_NONE  = 2'd3
  } fit_t;

  // result status codes
  localparam logic [2:0] ST_OK     = 3'd0;
  localparam logic [2:0] ST_SIZE   = 3'd1;
  localparam logic [2:0] ST_FULL   = 3'd2;
  localparam logic [2:0] ST_EXT    = 3'd3;
  localparam logic [2:0] ST_NOGAP  = 3'd4;
  localparam logic [2:0] ST_EMPTY  = 3'd5;
  localparam logic [2:0] ST_NONPOS = 3'd6;
  localparam logic [2:0] ST_NOROOM = 3'd7;

  // configuration register indexes
  localparam logic CFG_DISK_SIZE = 1'b0;
  localparam logic CFG_HEADER    = 1'b1;

  // how result fields are formed for a plain result
  typedef enum logic [2:0] {
    SEL_ZERO,
    SEL_SLOT,
    SEL_DEL,
    SEL_REGION
  } res_sel_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECODE,
    S_SCAN,
    S_PROC,
    S_FINAL,
    S_COMMIT,
    S_RZ_SCAN,
    S_RZ_END,
    S_EMIT
  } state_t;

  // controller to datapath commands
  typedef struct packed {
    logic       latch;
    logic       set_res;
    logic [2:0] res_st;
    res_sel_t   res_sel;
    logic       del;
    logic       rz_commit;
    logic       rz_init;
    logic       walk_init;
    logic       scan_step;
    logic       proc;
    logic       gap_last;
    logic       cr_commit;
    logic       rz_step;
    logic       rz_end;
    logic       emit;
  } ctl_cmd_t;

  // datapath to controller status
  typedef struct packed {
    op_t  op;
    logic req_zero;
    logic full;
    logic ext_conf;
    logic ts_empty;
    logic nonpos;
    logic grow;
    logic scan_last;
    logic found;
  } dp_stat_t;

endpackage

/* src/pga_controller.sv */
// command sequencer for the partition gap allocator
module pga_controller (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  input  pga_pkg::dp_stat_t stat,
  output pga_pkg::ctl_cmd_t cmd
);

  pga_pkg::state_t state_r, state_nxt;
  logic out_valid_r, out_valid_nxt;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      pga_pkg::S_IDLE: begin
        if (in_valid) state_nxt = pga_pkg::S_DECODE;
      end
      pga_pkg::S_DECODE: begin
        state_nxt = pga_pkg::S_EMIT;
        case (stat.op)
          pga_pkg::OP_CREATE: begin
            if (!stat.req_zero && !stat.full && !stat.ext_conf) state_nxt = pga_pkg::S_SCAN;
          end
          pga_pkg::OP_RESIZE: begin
            if (!stat.ts_empty && !stat.nonpos && stat.grow) state_nxt = pga_pkg::S_RZ_SCAN;
          end
          default: state_nxt = pga_pkg::S_EMIT;
        endcase
      end
      pga_pkg::S_SCAN: begin
        if (stat.scan_last) state_nxt = pga_pkg::S_PROC;
      end
      pga_pkg::S_PROC: begin
        state_nxt = stat.found ? pga_pkg::S_SCAN : pga_pkg::S_FINAL;
      end
      pga_pkg::S_FINAL:   state_nxt = pga_pkg::S_COMMIT;
      pga_pkg::S_COMMIT:  state_nxt = pga_pkg::S_EMIT;
      pga_pkg::S_RZ_SCAN: begin
        if (stat.scan_last) state_nxt = pga_pkg::S_RZ_END;
      end
      pga_pkg::S_RZ_END:  state_nxt = pga_pkg::S_EMIT;
      pga_pkg::S_EMIT: begin
        if (!out_valid_r || out_ready) state_nxt = pga_pkg::S_IDLE;
      end
      default: state_nxt = pga_pkg::S_IDLE;
    endcase
  end

  // command outputs
  always_comb begin
    cmd = '0;
    cmd.res_sel = pga_pkg::SEL_ZERO;
    in_ready = 1'b0;
    case (state_r)
      pga_pkg::S_IDLE: begin
        in_ready = 1'b1;
        cmd.latch = in_valid;
      end
      pga_pkg::S_DECODE: begin
        case (stat.op)
          pga_pkg::OP_CREATE: begin
            if (stat.req_zero) begin
              cmd.set_res = 1'b1;
              cmd.res_st = pga_pkg::ST_SIZE;
            end else if (stat.full) begin
              cmd.set_res = 1'b1;
              cmd.res_st = pga_pkg::ST_FULL;
            end else if (stat.ext_conf) begin
              cmd.set_res = 1'b1;
              cmd.res_st = pga_pkg::ST_EXT;
            end else begin
              cmd.walk_init = 1'b1;
            end
          end
          pga_pkg::OP_NOP: begin
            cmd.set_res = 1'b1;
            cmd.res_st = pga_pkg::ST_OK;
          end
          default: begin
            if (stat.ts_empty) begin
              cmd.set_res = 1'b1;
              cmd.res_st = pga_pkg::ST_EMPTY;
              cmd.res_sel = pga_pkg::SEL_SLOT;
            end else if (stat.op == pga_pkg::OP_DELETE) begin
              cmd.set_res = 1'b1;
              cmd.res_st = pga_pkg::ST_OK;
              cmd.res_sel = pga_pkg::SEL_DEL;
              cmd.del = 1'b1;
            end else if (stat.nonpos) begin
              cmd.set_res = 1'b1;
              cmd.res_st = pga_pkg::ST_NONPOS;
              cmd.res_sel = pga_pkg::SEL_REGION;
            end else if (!stat.grow) begin
              cmd.rz_commit = 1'b1;
            end else begin
              cmd.rz_init = 1'b1;
            end
          end
        endcase
      end
      pga_pkg::S_SCAN:    cmd.scan_step = 1'b1;
      pga_pkg::S_PROC:    cmd.proc = 1'b1;
      pga_pkg::S_FINAL:   cmd.gap_last = 1'b1;
      pga_pkg::S_COMMIT:  cmd.cr_commit = 1'b1;
      pga_pkg::S_RZ_SCAN: cmd.rz_step = 1'b1;
      pga_pkg::S_RZ_END:  cmd.rz_end = 1'b1;
      pga_pkg::S_EMIT:    cmd.emit = !out_valid_r || out_ready;
      default:            cmd = '0;
    endcase
  end

  // output valid holds until the transfer
  always_comb begin
    if (cmd.emit) out_valid_nxt = 1'b1;
    else if (out_ready) out_valid_nxt = 1'b0;
    else out_valid_nxt = out_valid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= pga_pkg::S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

endmodule

/* src/pga_datapath.sv */
// region table, gap walk and resize check datapath
module pga_datapath #(
  parameter int NUM_SLOTS = pga_pkg::NUM_SLOTS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic [1:0]         in_op,
  input  logic [30:0]        in_request_size,
  input  logic [1:0]         in_fit_mode,
  input  logic               in_make_extended,
  input  logic [1:0]         in_target_slot,
  input  logic signed [31:0] in_size_delta,
  input  logic               cfg_we,
  input  logic               cfg_index,
  input  logic [30:0]        cfg_wdata,
  input  pga_pkg::ctl_cmd_t  cmd,
  output pga_pkg::dp_stat_t  stat,
  output logic [2:0]         out_status,
  output logic [30:0]        out_region_start,
  output logic [1:0]         out_slot_used,
  output logic [30:0]        out_region_size
);

  localparam int SW = $clog2(NUM_SLOTS);
  localparam logic [SW-1:0] LAST_IDX = SW'(NUM_SLOTS - 1);

  // table and configuration
  logic [NUM_SLOTS-1:0] v_r, x_r;
  logic [30:0] st_r [NUM_SLOTS];
  logic [30:0] sz_r [NUM_SLOTS];
  logic [30:0] disk_r;
  logic [15:0] hdr_r;

  // latched command
  logic [1:0]         op_r, mode_r, ts_r;
  logic [30:0]        req_r;
  logic               mkext_r;
  logic signed [31:0] delta_r;

  // walk state
  logic [SW-1:0]        idx_r, best_idx_r;
  logic [NUM_SLOTS-1:0] vis_r;
  logic [31:0]          cur_r, best_end_r;
  logic [30:0]          best_start_r, pick_start_r, pick_len_r;
  logic                 best_found_r, pick_r;

  // resize state
  logic [30:0]        rs_r, rsz_r;
  logic signed [32:0] nsz_r;
  logic [31:0]        end_r;
  logic [32:0]        nend_r;
  logic               room_r;

  // pending result
  logic [2:0]  res_st_r;
  logic [30:0] res_start_r, res_size_r;
  logic [1:0]  res_slot_r;

  logic               rd_v;
  logic [30:0]        rd_start, rd_size;
  logic [SW-1:0]      ts_idx, free_idx, idx_inc;
  logic               ts_oob, cand;
  logic signed [32:0] nsz_c;
  logic [31:0]        end_c, s_ext, cur_max;
  logic [32:0]        nend_c;
  logic               gap_ok, last_ok, take_mid, take_last, hit;
  logic [30:0]        gap_len, last_len;

  // gap acceptance under the fit policy
  function automatic logic fit_take(input logic [30:0] len, input logic [30:0] need,
                                    input logic picked, input logic [30:0] plen,
                                    input logic [1:0] mode);
    logic t;
    t = 1'b0;
    if (len >= need) begin
      case (mode)
        pga_pkg::FIT_FIRST: t = !picked;
        pga_pkg::FIT_BEST:  t = !picked || (len < plen);
        pga_pkg::FIT_WORST: t = !picked || (len > plen);
        default:            t = 1'b0;
      endcase
    end
    return t;
  endfunction

  // single read port of the table
  always_comb begin
    rd_v = v_r[idx_r];
    rd_start = st_r[idx_r];
    rd_size = sz_r[idx_r];
  end

  // lowest free slot
  always_comb begin
    free_idx = '0;
    for (int i = NUM_SLOTS - 1; i >= 0; i--) begin
      if (!v_r[i]) free_idx = SW'(i);
    end
  end

  // arithmetic and compares
  always_comb begin
    ts_idx = SW'(ts_r);
    ts_oob = 32'(ts_r) >= NUM_SLOTS;
    idx_inc = (idx_r == LAST_IDX) ? '0 : idx_r + 1'b1;
    nsz_c = $signed({delta_r[31], delta_r}) + $signed({2'b00, rd_size});
    end_c = {1'b0, rd_start} + {1'b0, rd_size};
    nend_c = {1'b0, end_c} + {1'b0, delta_r};
    cand = rd_v && !vis_r[idx_r] && (!best_found_r || rd_start < best_start_r);
    s_ext = {1'b0, best_start_r};
    gap_ok = s_ext > cur_r;
    gap_len = 31'(s_ext - cur_r);
    take_mid = gap_ok && fit_take(gap_len, req_r, pick_r, pick_len_r, mode_r);
    cur_max = (best_end_r > cur_r) ? best_end_r : cur_r;
    last_ok = cur_r < {1'b0, disk_r};
    last_len = 31'({1'b0, disk_r} - cur_r);
    take_last = last_ok && fit_take(last_len, req_r, pick_r, pick_len_r, mode_r);
    hit = (idx_r != ts_idx) && rd_v && ({1'b0, rd_start} >= end_r)
          && ({2'b00, rd_start} < nend_r);
  end

  // status to the controller
  always_comb begin
    stat.op = pga_pkg::op_t'(op_r);
    stat.req_zero = req_r == '0;
    stat.full = &v_r;
    stat.ext_conf = mkext_r && |(v_r & x_r);
    stat.ts_empty = ts_oob || !rd_v;
    stat.nonpos = nsz_c[32] || (nsz_c == '0);
    stat.grow = !delta_r[31] && (delta_r != '0);
    stat.scan_last = idx_r == LAST_IDX;
    stat.found = best_found_r;
  end

  // control registers: valid and extended marks, configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
      x_r <= '0;
      disk_r <= '0;
      hdr_r <= 16'd512;
    end else begin
      if (cfg_we) begin
        if (cfg_index == pga_pkg::CFG_DISK_SIZE) disk_r <= cfg_wdata;
        else hdr_r <= cfg_wdata[15:0];
      end
      if (cmd.del) begin
        v_r[ts_idx] <= 1'b0;
        x_r[ts_idx] <= 1'b0;
      end
      if (cmd.cr_commit && pick_r) begin
        v_r[free_idx] <= 1'b1;
        x_r[free_idx] <= mkext_r;
      end
    end
  end

  // payload and working registers
  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      op_r <= in_op;
      req_r <= in_request_size;
      mode_r <= in_fit_mode;
      mkext_r <= in_make_extended;
      ts_r <= in_target_slot;
      delta_r <= in_size_delta;
      idx_r <= SW'(in_target_slot);
    end
    // plain results
    if (cmd.set_res) begin
      res_st_r <= cmd.res_st;
      case (cmd.res_sel)
        pga_pkg::SEL_SLOT: begin
          res_start_r <= '0;
          res_slot_r <= ts_r;
          res_size_r <= '0;
        end
        pga_pkg::SEL_DEL: begin
          res_start_r <= rd_start;
          res_slot_r <= ts_r;
          res_size_r <= '0;
        end
        pga_pkg::SEL_REGION: begin
          res_start_r <= rd_start;
          res_slot_r <= ts_r;
          res_size_r <= rd_size;
        end
        default: begin
          res_start_r <= '0;
          res_slot_r <= '0;
          res_size_r <= '0;
        end
      endcase
    end
    // shrink or zero change commits at once
    if (cmd.rz_commit) begin
      sz_r[ts_idx] <= nsz_c[30:0];
      res_st_r <= pga_pkg::ST_OK;
      res_start_r <= rd_start;
      res_slot_r <= ts_r;
      res_size_r <= nsz_c[30:0];
    end
    // gap walk setup
    if (cmd.walk_init) begin
      cur_r <= {16'd0, hdr_r};
      vis_r <= '0;
      best_found_r <= 1'b0;
      pick_r <= 1'b0;
      idx_r <= '0;
    end
    // lowest unvisited region by start, ties by slot
    if (cmd.scan_step) begin
      if (cand) begin
        best_found_r <= 1'b1;
        best_idx_r <= idx_r;
        best_start_r <= rd_start;
        best_end_r <= end_c;
      end
      idx_r <= idx_inc;
    end
    // gap below the chosen region, then advance cursor
    if (cmd.proc && best_found_r) begin
      if (take_mid) begin
        pick_r <= 1'b1;
        pick_start_r <= cur_r[30:0];
        pick_len_r <= gap_len;
      end
      cur_r <= cur_max;
      vis_r[best_idx_r] <= 1'b1;
      best_found_r <= 1'b0;
    end
    // gap up to the disk end
    if (cmd.gap_last && take_last) begin
      pick_r <= 1'b1;
      pick_start_r <= cur_r[30:0];
      pick_len_r <= last_len;
    end
    if (cmd.cr_commit) begin
      if (pick_r) begin
        st_r[free_idx] <= pick_start_r;
        sz_r[free_idx] <= req_r;
        res_st_r <= pga_pkg::ST_OK;
        res_start_r <= pick_start_r;
        res_slot_r <= 2'(free_idx);
        res_size_r <= req_r;
      end else begin
        res_st_r <= pga_pkg::ST_NOGAP;
        res_start_r <= '0;
        res_slot_r <= '0;
        res_size_r <= '0;
      end
    end
    // grow check setup
    if (cmd.rz_init) begin
      rs_r <= rd_start;
      rsz_r <= rd_size;
      nsz_r <= nsz_c;
      end_r <= end_c;
      nend_r <= nend_c;
      room_r <= 1'b1;
      idx_r <= '0;
    end
    if (cmd.rz_step) begin
      if (hit) room_r <= 1'b0;
      idx_r <= idx_inc;
    end
    if (cmd.rz_end) begin
      res_start_r <= rs_r;
      res_slot_r <= ts_r;
      if (room_r && (nend_r <= {2'b00, disk_r})) begin
        sz_r[ts_idx] <= nsz_r[30:0];
        res_st_r <= pga_pkg::ST_OK;
        res_size_r <= nsz_r[30:0];
      end else begin
        res_st_r <= pga_pkg::ST_NOROOM;
        res_size_r <= rsz_r;
      end
    end
    // output register
    if (cmd.emit) begin
      out_status <= res_st_r;
      out_region_start <= res_start_r;
      out_slot_used <= res_slot_r;
      out_region_size <= res_size_r;
    end
  end

endmodule

/* src/partition_gap_allocator_core.sv */
// top level of the partition gap allocator, one command at a time, in_ready high only when idle
// a create walks the table in one scan pass per valid region plus a final pass, a resize with
//   growth scans every slot once, and other commands go from decode straight to the emit step
// a result not yet taken holds the next command in its emit step until out_ready
// synchronous active-low reset empties all slots, disk size 0, header 512
module partition_gap_allocator_core #(
  parameter int NUM_SLOTS = pga_pkg::NUM_SLOTS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         in_op,
  input  logic [30:0]        in_request_size,
  input  logic [1:0]         in_fit_mode,
  input  logic               in_make_extended,
  input  logic [1:0]         in_target_slot,
  input  logic signed [31:0] in_size_delta,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [2:0]         out_status,
  output logic [30:0]        out_region_start,
  output logic [1:0]         out_slot_used,
  output logic [30:0]        out_region_size,
  input  logic               cfg_we,
  input  logic               cfg_index,
  input  logic [30:0]        cfg_wdata
);

  pga_pkg::ctl_cmd_t cmd;
  pga_pkg::dp_stat_t stat;

  pga_controller u_ctl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  pga_datapath #(.NUM_SLOTS(NUM_SLOTS)) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_op            (in_op),
    .in_request_size  (in_request_size),
    .in_fit_mode      (in_fit_mode),
    .in_make_extended (in_make_extended),
    .in_target_slot   (in_target_slot),
    .in_size_delta    (in_size_delta),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata),
    .cmd              (cmd),
    .stat             (stat),
    .out_status       (out_status),
    .out_region_start (out_region_start),
    .out_slot_used    (out_slot_used),
    .out_region_size  (out_region_size)
  );

`ifndef SYNTHESIS
  // one command in flight: no transfer right after a transfer
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken while a command is in flight");

  // refused creates carry all-zero fields
  a_refused_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == pga_pkg::ST_SIZE || out_status == pga_pkg::ST_FULL ||
                  out_status == pga_pkg::ST_EXT || out_status == pga_pkg::ST_NOGAP)
    |-> out_region_start == '0 && out_slot_used == '0 && out_region_size == '0)
    else $error("refused create with nonzero fields");

  // empty slot answers carry no region
  a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == pga_pkg::ST_EMPTY
    |-> out_region_start == '0 && out_region_size == '0)
    else $error("empty slot result with region fields");
`endif

endmodule

/* bench/partition_gap_allocator_core_test.sv */
// self-checking bench for the partition gap allocator core
module partition_gap_allocator_core_test;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    pga_pkg::op_t       op;
    logic [30:0]        req;
    pga_pkg::fit_t      fit;
    logic               ext;
    logic [1:0]         slot;
    logic signed [31:0] delta;
  } command_t;

  typedef struct {
    logic [2:0]  st;
    logic [30:0] start;
    logic [1:0]  slot;
    logic [30:0] size;
  } answer_t;

  localparam int SLOTS = 4;
  localparam int CYCLE_LIMIT = 1000000;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_ready;
  logic [1:0] in_op;
  logic [30:0] in_request_size;
  logic [1:0] in_fit_mode;
  logic in_make_extended;
  logic [1:0] in_target_slot;
  logic signed [31:0] in_size_delta;
  logic out_valid;
  logic out_ready;
  logic [2:0] out_status;
  logic [30:0] out_region_start;
  logic [1:0] out_slot_used;
  logic [30:0] out_region_size;
  logic cfg_we;
  logic cfg_index;
  logic [30:0] cfg_wdata;

  partition_gap_allocator_core DUT (.*);

  // table copy kept by the bench
  longint disk_bytes;
  longint header_len;
  bit     tbl_valid [SLOTS];
  longint tbl_start [SLOTS];
  longint tbl_size  [SLOTS];
  bit     tbl_ext   [SLOTS];

  command_t cmd_queue[$];
  answer_t  answer_queue[$];
  int       errors;
  int       cycles;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // place a new region, mirroring the gap walk
  function automatic bit locate_gap(longint need, pga_pkg::fit_t mode, output longint where);
    int     order[SLOTS];
    int     n;
    int     j;
    int     g;
    int     pick;
    longint cur;
    longint s;
    longint e;
    longint gs[SLOTS+1];
    longint gl[SLOTS+1];
    n = 0;
    g = 0;
    pick = -1;
    cur = header_len;
    where = 0;
    for (int i = 0; i < SLOTS; i++) begin
      if (tbl_valid[i]) begin
        j = n;
        while (j > 0 && tbl_start[order[j-1]] > tbl_start[i]) begin
          order[j] = order[j-1];
          j--;
        end
        order[j] = i;
        n++;
      end
    end
    for (int i = 0; i < n; i++) begin
      s = tbl_start[order[i]];
      e = s + tbl_size[order[i]];
      if (s > cur) begin
        gs[g] = cur;
        gl[g] = s - cur;
        g++;
      end
      if (e > cur) cur = e;
    end
    if (cur < disk_bytes) begin
      gs[g] = cur;
      gl[g] = disk_bytes - cur;
      g++;
    end
    for (int i = 0; i < g; i++) begin
      if (gl[i] >= need) begin
        case (mode)
          pga_pkg::FIT_FIRST: if (pick < 0) pick = i;
          pga_pkg::FIT_BEST:  if (pick < 0 || gl[i] < gl[pick]) pick = i;
          pga_pkg::FIT_WORST: if (pick < 0 || gl[i] > gl[pick]) pick = i;
          default: ;
        endcase
      end
    end
    if (pick < 0) return 1'b0;
    where = gs[pick];
    return 1'b1;
  endfunction

  // apply one command to the table copy and return its answer
  function automatic answer_t apply_command(command_t c);
    answer_t r;
    int      free_slot;
    bit      has_ext;
    bit      room;
    longint  where;
    longint  s;
    longint  sz;
    longint  nsz;
    longint  dlt;
    longint  nend;
    r = '{pga_pkg::ST_OK, 31'd0, 2'd0, 31'd0};
    dlt = longint'(c.delta);
    if (c.op == pga_pkg::OP_CREATE) begin
      free_slot = -1;
      has_ext = 1'b0;
      for (int i = 0; i < SLOTS; i++) begin
        if (tbl_valid[i]) begin
          if (tbl_ext[i]) has_ext = 1'b1;
        end else if (free_slot < 0) begin
          free_slot = i;
        end
      end
      if (c.req == '0) r.st = pga_pkg::ST_SIZE;
      else if (free_slot < 0) r.st = pga_pkg::ST_FULL;
      else if (c.ext && has_ext) r.st = pga_pkg::ST_EXT;
      else if (!locate_gap(longint'(c.req), c.fit, where)) r.st = pga_pkg::ST_NOGAP;
      else begin
        tbl_valid[free_slot] = 1'b1;
        tbl_start[free_slot] = where & 64'h7FFF_FFFF;
        tbl_size[free_slot] = longint'(c.req);
        tbl_ext[free_slot] = c.ext;
        r = '{pga_pkg::ST_OK, where[30:0], free_slot[1:0], c.req};
      end
    end else if (c.op == pga_pkg::OP_NOP) begin
      r = '{pga_pkg::ST_OK, 31'd0, 2'd0, 31'd0};
    end else if (!tbl_valid[c.slot]) begin
      r = '{pga_pkg::ST_EMPTY, 31'd0, c.slot, 31'd0};
    end else if (c.op == pga_pkg::OP_DELETE) begin
      r = '{pga_pkg::ST_OK, tbl_start[c.slot][30:0], c.slot, 31'd0};
      tbl_valid[c.slot] = 1'b0;
      tbl_start[c.slot] = 0;
      tbl_size[c.slot] = 0;
      tbl_ext[c.slot] = 1'b0;
    end else begin
      s = tbl_start[c.slot];
      sz = tbl_size[c.slot];
      nsz = sz + dlt;
      r = '{pga_pkg::ST_OK, s[30:0], c.slot, sz[30:0]};
      room = 1'b1;
      if (dlt > 0) begin
        nend = s + sz + dlt;
        if (nend > disk_bytes) room = 1'b0;
        for (int i = 0; i < SLOTS; i++)
          if (i != int'(c.slot) && tbl_valid[i] && tbl_start[i] >= s + sz
              && tbl_start[i] < nend)
            room = 1'b0;
      end
      if (nsz <= 0) r.st = pga_pkg::ST_NONPOS;
      else if (!room) r.st = pga_pkg::ST_NOROOM;
      else begin
        tbl_size[c.slot] = nsz & 64'h7FFF_FFFF;
        r.size = nsz[30:0];
      end
    end
    return r;
  endfunction

  // sender: bursts of transfers separated by random gaps
  int burst_left;
  int gap_left;
  always @(posedge clk) begin
    command_t nxt;
    bit       load;
    if (!rst_n) begin
      in_valid <= 1'b0;
      burst_left <= 0;
      gap_left <= 0;
    end else begin
      load = 1'b0;
      if (in_valid && in_ready) begin
        answer_queue.insert(answer_queue.size(), apply_command('{pga_pkg::op_t'(in_op),
          in_request_size, pga_pkg::fit_t'(in_fit_mode), in_make_extended, in_target_slot,
          in_size_delta}));
        if (burst_left > 0 && cmd_queue.size() > 0) begin
          load = 1'b1;
          burst_left <= burst_left - 1;
        end else begin
          gap_left <= ($urandom_range(0, 3) == 0) ? 0 : int'($urandom_range(1, 20));
        end
      end else if (!in_valid) begin
        if (gap_left > 0) gap_left <= gap_left - 1;
        else if (cmd_queue.size() > 0) begin
          load = 1'b1;
          burst_left <= int'($urandom_range(0, 8));
        end
      end
      if (load) begin
        nxt = cmd_queue.pop_front();
        in_op <= nxt.op;
        in_request_size <= nxt.req;
        in_fit_mode <= nxt.fit;
        in_make_extended <= nxt.ext;
        in_target_slot <= nxt.slot;
        in_size_delta <= nxt.delta;
        in_valid <= 1'b1;
      end else if (in_valid && in_ready) begin
        in_valid <= 1'b0;
      end
    end
  end

  // receiver stall pattern: random ready at a changing density
  int ready_pct;
  always @(posedge clk) begin
    if (cycles % 64 == 0)
      ready_pct <= ($urandom_range(0, 2) == 0) ? 100 : int'($urandom_range(20, 90));
    out_ready <= (int'($urandom_range(1, 100)) <= ready_pct);
  end

  // result checker
  always @(posedge clk) begin
    answer_t x;
    cycles <= cycles + 1;
    if (rst_n && out_valid && out_ready) begin
      if (answer_queue.size() == 0) begin
        $error("result transfer with nothing expected");
        errors++;
      end else begin
        x = answer_queue.pop_front();
        if (out_status !== x.st) begin
          $error("status expected %0d actual %0d", x.st, out_status);
          errors++;
        end
        if (out_region_start !== x.start) begin
          $error("region_start expected %0d actual %0d", x.start, out_region_start);
          errors++;
        end
        if (out_slot_used !== x.slot) begin
          $error("slot_used expected %0d actual %0d", x.slot, out_slot_used);
          errors++;
        end
        if (out_region_size !== x.size) begin
          $error("region_size expected %0d actual %0d", x.size, out_region_size);
          errors++;
        end
      end
    end
    if (cycles > CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  task automatic add_cmd(pga_pkg::op_t op, int req, pga_pkg::fit_t fit, int ext, int slot,
                         int delta);
    command_t c;
    c = '{op, 31'(req), fit, 1'(ext), 2'(slot), 32'(delta)};
    cmd_queue.insert(cmd_queue.size(), c);
  endtask

  task automatic write_reg(logic idx, logic [30:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    if (idx == pga_pkg::CFG_DISK_SIZE) disk_bytes = longint'(val);
    else header_len = longint'(val[15:0]);
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic drain;
    while (cmd_queue.size() > 0 || in_valid || answer_queue.size() > 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  // random command weighted toward sizes that fit the disk
  function automatic command_t random_cmd;
    command_t c;
    int       k;
    longint   span;
    k = $urandom_range(0, 19);
    c.op = (k < 8) ? pga_pkg::OP_CREATE : (k < 12) ? pga_pkg::OP_DELETE :
           (k < 19) ? pga_pkg::OP_RESIZE : pga_pkg::OP_NOP;
    c.fit = pga_pkg::fit_t'(2'($urandom_range(0, 12) == 0 ? 3 : $urandom_range(0, 2)));
    c.ext = ($urandom_range(0, 3) == 0);
    c.slot = 2'($urandom_range(0, 3));
    span = disk_bytes / 4 + 1;
    if (span > 32'h3FFF_FFFF) span = 32'h3FFF_FFFF;
    case ($urandom_range(0, 15))
      0: c.req = 31'd0;
      1: c.req = 31'($urandom());
      default: c.req = 31'($urandom_range(1, int'(span)));
    endcase
    case ($urandom_range(0, 9))
      0: c.delta = $signed($urandom());
      1: c.delta = 0;
      2: c.delta = -int'(tbl_size[c.slot]);
      default: c.delta = int'($urandom_range(0, 2 * int'(span / 4 + 1))) - int'(span / 4 + 1);
    endcase
    return c;
  endfunction

  // stimulus and phase control
  initial begin
    errors = 0;
    cycles = 0;
    ready_pct = 100;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_op = pga_pkg::OP_NOP;
    in_request_size = '0;
    in_fit_mode = pga_pkg::FIT_FIRST;
    in_make_extended = 1'b0;
    in_target_slot = '0;
    in_size_delta = '0;
    out_ready = 1'b0;
    cfg_we = 1'b0;
    cfg_index = pga_pkg::CFG_DISK_SIZE;
    cfg_wdata = '0;
    disk_bytes = 0;
    header_len = 512;
    for (int i = 0; i < SLOTS; i++) begin
      tbl_valid[i] = 0;
      tbl_start[i] = 0;
      tbl_size[i] = 0;
      tbl_ext[i] = 0;
    end
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // reset values: disk of zero bytes leaves no gap
    add_cmd(pga_pkg::OP_CREATE, 100, pga_pkg::FIT_FIRST, 0, 0, 0);
    add_cmd(pga_pkg::OP_RESIZE, 0, pga_pkg::FIT_FIRST, 0, 0, 5);
    drain();

    // directed walk over every command and refusal
    write_reg(pga_pkg::CFG_DISK_SIZE, 31'd10000);
    write_reg(pga_pkg::CFG_HEADER, 31'd512);
    add_cmd(pga_pkg::OP_CREATE, 1000, pga_pkg::FIT_FIRST, 0, 0, 0);
    add_cmd(pga_pkg::OP_CREATE, 0, pga_pkg::FIT_FIRST, 0, 0, 0);
    add_cmd(pga_pkg::OP_CREATE, 500, pga_pkg::FIT_BEST, 1, 0, 0);
    add_cmd(pga_pkg::OP_CREATE, 500, pga_pkg::FIT_BEST, 1, 0, 0);
    add_cmd(pga_pkg::OP_CREATE, 2000, pga_pkg::FIT_WORST, 0, 0, 0);
    add_cmd(pga_pkg::OP_CREATE, 1000, pga_pkg::FIT_FIRST, 0, 0, 0);
    add_cmd(pga_pkg::OP_CREATE, 10, pga_pkg::FIT_FIRST, 0, 0, 0);
    add_cmd(pga_pkg::OP_RESIZE, 0, pga_pkg::FIT_FIRST, 0, 0, 1);
    add_cmd(pga_pkg::OP_RESIZE, 0, pga_pkg::FIT_FIRST, 0, 3, -100);
    add_cmd(pga_pkg::OP_RESIZE, 0, pga_pkg::FIT_FIRST, 0, 0, -1000);
    add_cmd(pga_pkg::OP_DELETE, 0, pga_pkg::FIT_FIRST, 0, 1, 0);
    add_cmd(pga_pkg::OP_CREATE, 200, pga_pkg::FIT_BEST, 0, 0, 0);
    add_cmd(pga_pkg::OP_DELETE, 0, pga_pkg::FIT_FIRST, 0, 3, 0);
    add_cmd(pga_pkg::OP_CREATE, 50, pga_pkg::FIT_NONE, 0, 0, 0);
    add_cmd(pga_pkg::OP_CREATE, 32'h7FFF_FFFF, pga_pkg::FIT_WORST, 1, 0, 0);
    add_cmd(pga_pkg::OP_RESIZE, 0, pga_pkg::FIT_FIRST, 0, 3, 4);
    add_cmd(pga_pkg::OP_DELETE, 0, pga_pkg::FIT_FIRST, 0, 3, 0);
    add_cmd(pga_pkg::OP_NOP, 32'h7FFF_FFFF, pga_pkg::FIT_NONE, 1, 3, -1);
    add_cmd(pga_pkg::OP_RESIZE, 0, pga_pkg::FIT_FIRST, 0, 2, 32'sh7FFF_FFFF);
    add_cmd(pga_pkg::OP_RESIZE, 0, pga_pkg::FIT_FIRST, 0, 2, 32'sh8000_0000);
    add_cmd(pga_pkg::OP_RESIZE, 0, pga_pkg::FIT_FIRST, 0, 2, 6000);
    add_cmd(pga_pkg::OP_RESIZE, 0, pga_pkg::FIT_FIRST, 0, 0, -999);
    drain();

    // random phases across register settings, extremes first
    for (int p = 0; p < 10; p++) begin
      case (p)
        0: begin
          write_reg(pga_pkg::CFG_DISK_SIZE, 31'h7FFF_FFFF);
          write_reg(pga_pkg::CFG_HEADER, 31'h0000_FFFF);
        end
        1: begin
          write_reg(pga_pkg::CFG_DISK_SIZE, 31'd0);
          write_reg(pga_pkg::CFG_HEADER, 31'd0);
        end
        2: begin
          write_reg(pga_pkg::CFG_DISK_SIZE, 31'd70000);
          write_reg(pga_pkg::CFG_HEADER, 31'h0000_FFFF);
        end
        3: begin
          write_reg(pga_pkg::CFG_DISK_SIZE, 31'($urandom()));
          write_reg(pga_pkg::CFG_HEADER, 31'($urandom()));
        end
        default: begin
          write_reg(pga_pkg::CFG_DISK_SIZE, 31'($urandom_range(1000, 1000000)));
          write_reg(pga_pkg::CFG_HEADER, 31'($urandom_range(0, 2000)));
        end
      endcase
      for (int n = 0; n < 125; n++) begin
        cmd_queue.insert(cmd_queue.size(), random_cmd());
        // keep table in step with generation by waiting on a small backlog
        while (cmd_queue.size() > 4) @(posedge clk);
      end
      drain();
    end

    if (errors == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end
endmodule

/* sim.f */
src/pga_pkg.sv
src/pga_controller.sv
src/pga_datapath.sv
src/partition_gap_allocator_core.sv
bench/partition_gap_allocator_core_test.sv
